// ===== hdl/dcp_pkg.sv =====
`default_nettype none
package dcp_pkg;

  localparam int COORD_W   = 32;
  localparam int MASS_W    = 32;
  localparam int REST_W    = 31;
  localparam int STIFF_W   = 17;
  localparam int EPS_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_EPSILON = 1'b1;

  localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;
  localparam logic [STIFF_W-1:0] K_ONE       = 17'd65536;
  localparam logic [STIFF_W-1:0] K_RIGID     = 17'd16384;
  localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd1;

  localparam int MAG_W   = 32;   // |a - b| per axis
  localparam int SUMSQ_W = 66;   // sum of squares, Q34.32
  localparam int LEN_W   = 33;   // floor square root
  localparam int ROOT_W  = 34;   // square root working register
  localparam int DEN_W   = 34;   // len + epsilon
  localparam int ERR_W   = 33;   // |len - rest|
  localparam int CM_W    = 34;   // correction magnitude per axis
  localparam int FRAC_W  = 17;   // quotients and scales, at most 1.0 in Q1.16
  localparam int DIVN_W  = 49;   // divider dividend
  localparam int DIVD_W  = 34;   // divider divisor

  localparam int SQRT_STAGES = 17;  // 33 root bits, two per stage
  localparam int DIV_STAGES  = 9;   // 17 quotient bits, two per stage

  typedef struct packed {
    logic signed [COORD_W-1:0] point_a_x;
    logic signed [COORD_W-1:0] point_a_y;
    logic signed [COORD_W-1:0] point_a_z;
    logic signed [COORD_W-1:0] point_b_x;
    logic signed [COORD_W-1:0] point_b_y;
    logic signed [COORD_W-1:0] point_b_z;
    logic        [MASS_W-1:0]  inv_mass_a;
    logic        [MASS_W-1:0]  inv_mass_b;
    logic        [REST_W-1:0]  rest_length;
    logic                      rigid_body;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_a_x;
    logic signed [COORD_W-1:0] new_a_y;
    logic signed [COORD_W-1:0] new_a_z;
    logic signed [COORD_W-1:0] new_b_x;
    logic signed [COORD_W-1:0] new_b_y;
    logic signed [COORD_W-1:0] new_b_z;
    logic                      massless_flag;
  } out_t;

endpackage
`default_nettype wire

// ===== hdl/distance_constraint_projection_core.sv =====
`default_nettype none
// Distance constraint projection, fully pipelined.
// Throughput: one item per cycle; the square root (17 stages) and the direction
// dividers (9 stages) set the depth. The pipeline only holds while its last stage
// is full and the output register waits on out_ready.
// Reset (synchronous, rst_n low) empties the pipeline and restores both registers.
module distance_constraint_projection_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire dcp_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output dcp_pkg::out_t                          out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [dcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dcp_pkg::STIFF_W-1:0]       cfg_data
);

  localparam int CW = dcp_pkg::COORD_W;
  localparam int FW = dcp_pkg::FRAC_W;

  // Stage numbers: the index of each pipeline register, counting the input register as stage 1.
  localparam int S_IN   = 1;
  localparam int S_CTX  = 2;
  localparam int S_SQ   = 3;
  localparam int S_SUM  = 4;
  localparam int S_LEN  = S_SUM + dcp_pkg::SQRT_STAGES;
  localparam int S_ERR  = S_LEN + 1;
  localparam int S_NDIV = S_ERR + dcp_pkg::DIV_STAGES;
  localparam int S_CM   = S_NDIV + 1;
  localparam int S_LAST = S_CM + 1;
  localparam int S_W    = S_IN + dcp_pkg::DIV_STAGES;
  localparam int S_G    = S_W + 1;

  localparam logic [31:0] HALF = 32'd32768;

  typedef struct packed {
    logic [2:0][CW-1:0]               pa;
    logic [2:0][CW-1:0]               pb;
    logic [2:0][dcp_pkg::MAG_W-1:0]   mag;
    logic [2:0]                       dneg;
    logic                             massless;
    logic                             rigid;
    logic [dcp_pkg::REST_W-1:0]       rest;
  } ctx_t;

  logic [dcp_pkg::STIFF_W-1:0] stiff_r;
  logic [dcp_pkg::EPS_W-1:0]   eps_r;

  logic                        v_r [S_IN:S_LAST];
  logic                        en;
  dcp_pkg::in_t                in_r;
  ctx_t                        ctx_nxt;
  ctx_t                        ctx_r [S_CTX:S_LAST];
  logic [63:0]                 sq_r [3];
  logic [dcp_pkg::SUMSQ_W-1:0] sumsq_r;
  logic [dcp_pkg::LEN_W-1:0]   len;

  logic [dcp_pkg::ERR_W-1:0]   errmag_r  [S_ERR:S_NDIV];
  logic                        denzero_r [S_ERR:S_NDIV];
  logic                        errneg_r  [S_ERR:S_LAST];
  logic [dcp_pkg::DEN_W-1:0]   den_r;
  logic [FW-1:0]               nmag [3];
  logic [dcp_pkg::CM_W-1:0]    cm_r [3];

  logic [32:0]                 sumw;
  logic [dcp_pkg::DIVN_W-1:0]  wdiv_a;
  logic [dcp_pkg::DIVN_W-1:0]  wdiv_b;
  logic [FW-1:0]               fa;
  logic [FW-1:0]               fb;
  logic [FW-1:0]               k_eff;
  logic [FW-1:0]               ga_r [S_G:S_CM];
  logic [FW-1:0]               gb_r [S_G:S_CM];
  logic [dcp_pkg::CM_W-1:0]    da_r [3];
  logic [dcp_pkg::CM_W-1:0]    db_r [3];

  logic                        out_valid_r;
  dcp_pkg::out_t               out_r;
  dcp_pkg::out_t               out_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= dcp_pkg::STIFF_RESET;
      eps_r   <= dcp_pkg::EPS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dcp_pkg::CFG_STIFFNESS:      stiff_r <= cfg_data;
        dcp_pkg::CFG_LENGTH_EPSILON: eps_r   <= cfg_data[dcp_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished item in the last stage has nowhere to go.
  assign en       = !(v_r[S_LAST] && out_valid_r && !out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = S_IN; i <= S_LAST; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[S_IN] <= in_valid;
      for (int i = S_IN + 1; i <= S_LAST; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Separation per axis.
  always_comb begin
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [CW:0]        d;
    a = {in_r.point_a_z, in_r.point_a_y, in_r.point_a_x};
    b = {in_r.point_b_z, in_r.point_b_y, in_r.point_b_x};
    ctx_nxt.pa = a;
    ctx_nxt.pb = b;
    for (int c = 0; c < 3; c++) begin
      d = {a[c][CW-1], a[c]} - {b[c][CW-1], b[c]};
      ctx_nxt.dneg[c] = d[CW];
      ctx_nxt.mag[c]  = d[CW] ? CW'(-d) : d[CW-1:0];
    end
    ctx_nxt.massless = (in_r.inv_mass_a == '0) && (in_r.inv_mass_b == '0);
    ctx_nxt.rigid    = in_r.rigid_body;
    ctx_nxt.rest     = in_r.rest_length;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r         <= in_data;
      ctx_r[S_CTX] <= ctx_nxt;
      for (int i = S_CTX + 1; i <= S_LAST; i++) ctx_r[i] <= ctx_r[i-1];
      for (int c = 0; c < 3; c++) sq_r[c] <= ctx_r[S_CTX].mag[c] * ctx_r[S_CTX].mag[c];
      sumsq_r <= dcp_pkg::SUMSQ_W'(sq_r[0]) + dcp_pkg::SUMSQ_W'(sq_r[1])
               + dcp_pkg::SUMSQ_W'(sq_r[2]);
    end
  end

  dcp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sumsq_r),
    .root (len)
  );

  // Error against the rest length and the direction divisor.
  always_ff @(posedge clk) begin
    logic [dcp_pkg::LEN_W:0] diff;
    logic [dcp_pkg::DEN_W-1:0] den;
    if (en) begin
      diff = {1'b0, len} - (dcp_pkg::LEN_W+1)'(ctx_r[S_LEN].rest);
      den  = dcp_pkg::DEN_W'(len) + dcp_pkg::DEN_W'(eps_r);
      errneg_r[S_ERR]  <= diff[dcp_pkg::LEN_W];
      errmag_r[S_ERR]  <= diff[dcp_pkg::LEN_W] ? dcp_pkg::ERR_W'(-diff)
                                               : diff[dcp_pkg::ERR_W-1:0];
      denzero_r[S_ERR] <= (den == '0);
      den_r            <= den;
      for (int i = S_ERR + 1; i <= S_NDIV; i++) begin
        errmag_r[i]  <= errmag_r[i-1];
        denzero_r[i] <= denzero_r[i-1];
      end
      for (int i = S_ERR + 1; i <= S_LAST; i++) errneg_r[i] <= errneg_r[i-1];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_axis
    logic [FW-1:0] nraw;
    dcp_div u_ndiv (
      .clk      (clk),
      .en       (en),
      .dividend ({1'b0, ctx_r[S_ERR].mag[c], 16'b0}),
      .divisor  (den_r),
      .quot     (nraw)
    );
    // A zero divisor only occurs with zero separation; the direction is zero then.
    assign nmag[c] = denzero_r[S_NDIV] ? '0 : nraw;
  end

  // Weight fractions, rounded to nearest.
  assign sumw   = {1'b0, in_r.inv_mass_a} + {1'b0, in_r.inv_mass_b};
  assign wdiv_a = {1'b0, in_r.inv_mass_a, 16'b0} + dcp_pkg::DIVN_W'(sumw[32:1]);
  assign wdiv_b = {1'b0, in_r.inv_mass_b, 16'b0} + dcp_pkg::DIVN_W'(sumw[32:1]);

  dcp_div u_wdiv_a (
    .clk      (clk),
    .en       (en),
    .dividend (wdiv_a),
    .divisor  (dcp_pkg::DIVD_W'(sumw)),
    .quot     (fa)
  );

  dcp_div u_wdiv_b (
    .clk      (clk),
    .en       (en),
    .dividend (wdiv_b),
    .divisor  (dcp_pkg::DIVD_W'(sumw)),
    .quot     (fb)
  );

  assign k_eff = ctx_r[S_W].rigid ? dcp_pkg::K_RIGID
               : ((stiff_r > dcp_pkg::K_ONE) ? dcp_pkg::K_ONE : stiff_r);

  always_ff @(posedge clk) begin
    logic [2*FW-1:0] pa_k;
    logic [2*FW-1:0] pb_k;
    logic [dcp_pkg::ERR_W+FW-1:0] pc;
    logic [dcp_pkg::CM_W+FW-1:0]  pd;
    if (en) begin
      pa_k = fa * k_eff;
      pb_k = fb * k_eff;
      ga_r[S_G] <= FW'((pa_k + (2*FW)'(HALF)) >> 16);
      gb_r[S_G] <= FW'((pb_k + (2*FW)'(HALF)) >> 16);
      for (int i = S_G + 1; i <= S_CM; i++) begin
        ga_r[i] <= ga_r[i-1];
        gb_r[i] <= gb_r[i-1];
      end
      for (int c = 0; c < 3; c++) begin
        pc = errmag_r[S_NDIV] * nmag[c];
        cm_r[c] <= dcp_pkg::CM_W'((pc + (dcp_pkg::ERR_W+FW)'(HALF)) >> 16);
        pd = cm_r[c] * ga_r[S_CM];
        da_r[c] <= dcp_pkg::CM_W'((pd + (dcp_pkg::CM_W+FW)'(HALF)) >> 16);
        pd = cm_r[c] * gb_r[S_CM];
        db_r[c] <= dcp_pkg::CM_W'((pd + (dcp_pkg::CM_W+FW)'(HALF)) >> 16);
      end
    end
  end

  function automatic logic [CW-1:0] sat32(input logic signed [CW+3:0] v);
    logic signed [CW+3:0] hi;
    logic signed [CW+3:0] lo;
    hi = (CW+4)'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Apply the moves: a goes against the correction, b along it.
  always_comb begin
    logic [2:0][CW-1:0] na;
    logic [2:0][CW-1:0] nb;
    logic signed [CW+3:0] pa;
    logic signed [CW+3:0] pb;
    logic signed [CW+3:0] ma;
    logic signed [CW+3:0] mb;
    logic negprod;
    for (int c = 0; c < 3; c++) begin
      negprod = errneg_r[S_LAST] != ctx_r[S_LAST].dneg[c];
      pa = (CW+4)'($signed(ctx_r[S_LAST].pa[c]));
      pb = (CW+4)'($signed(ctx_r[S_LAST].pb[c]));
      ma = $signed((CW+4)'(da_r[c]));
      mb = $signed((CW+4)'(db_r[c]));
      if (ctx_r[S_LAST].massless) begin
        na[c] = ctx_r[S_LAST].pa[c];
        nb[c] = ctx_r[S_LAST].pb[c];
      end else begin
        na[c] = sat32(negprod ? pa + ma : pa - ma);
        nb[c] = sat32(negprod ? pb - mb : pb + mb);
      end
    end
    out_nxt.new_a_x       = na[0];
    out_nxt.new_a_y       = na[1];
    out_nxt.new_a_z       = na[2];
    out_nxt.new_b_x       = nb[0];
    out_nxt.new_b_y       = nb[1];
    out_nxt.new_b_z       = nb[2];
    out_nxt.massless_flag = ctx_r[S_LAST].massless;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= v_r[S_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== hdl/dcp_div.sv =====
`default_nettype none
// Pipelined restoring divider. The dividend must be below divisor * 2^FRAC_W,
// so the quotient fits FRAC_W bits and the upper dividend bits start as remainder.
module dcp_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [dcp_pkg::DIVN_W-1:0]    dividend,
  input  wire logic [dcp_pkg::DIVD_W-1:0]    divisor,
  output logic      [dcp_pkg::FRAC_W-1:0]    quot
);

  localparam int NS = dcp_pkg::DIV_STAGES;
  localparam int QB = dcp_pkg::FRAC_W;
  localparam int DW = dcp_pkg::DIVD_W;
  localparam int NW = dcp_pkg::DIVN_W;

  logic [DW-1:0] rem_in  [NS];
  logic [QB-1:0] low_in  [NS];
  logic [QB-1:0] q_in    [NS];
  logic [DW-1:0] d_in    [NS];
  logic [DW-1:0] rem_nxt [NS];
  logic [QB-1:0] low_nxt [NS];
  logic [QB-1:0] q_nxt   [NS];
  logic [DW-1:0] rem_r   [NS];
  logic [QB-1:0] low_r   [NS];
  logic [QB-1:0] q_r     [NS];
  logic [DW-1:0] d_r     [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s] = DW'(dividend[NW-1:QB]);
      assign low_in[s] = dividend[QB-1:0];
      assign q_in[s]   = '0;
      assign d_in[s]   = divisor;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign low_in[s] = low_r[s-1];
      assign q_in[s]   = q_r[s-1];
      assign d_in[s]   = d_r[s-1];
    end

    always_comb begin
      logic [DW:0] cand;
      rem_nxt[s] = rem_in[s];
      low_nxt[s] = low_in[s];
      q_nxt[s]   = q_in[s];
      for (int t = 0; t < 2; t++) begin
        if (s * 2 + t < QB) begin
          cand       = {rem_nxt[s], low_nxt[s][QB-1]};
          low_nxt[s] = {low_nxt[s][QB-2:0], 1'b0};
          if (cand >= {1'b0, d_in[s]}) begin
            cand       = cand - {1'b0, d_in[s]};
            q_nxt[s]   = {q_nxt[s][QB-2:0], 1'b1};
          end else begin
            q_nxt[s]   = {q_nxt[s][QB-2:0], 1'b0};
          end
          rem_nxt[s] = cand[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        low_r[s] <= low_nxt[s];
        q_r[s]   <= q_nxt[s];
        d_r[s]   <= d_in[s];
      end
    end
  end

  assign quot = q_r[NS-1];

endmodule
`default_nettype wire

// ===== hdl/dcp_sqrt.sv =====
`default_nettype none
// Pipelined digit-by-digit floor square root, two result bits per stage.
module dcp_sqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [dcp_pkg::SUMSQ_W-1:0]   rad,
  output logic      [dcp_pkg::LEN_W-1:0]     root
);

  localparam int NS = dcp_pkg::SQRT_STAGES;
  localparam int RW = dcp_pkg::SUMSQ_W;
  localparam int TW = dcp_pkg::ROOT_W;
  localparam int MW = TW + 1;          // partial remainder width
  localparam int STEPS = RW / 2;

  logic [RW-1:0] rad_in   [NS];
  logic [MW-1:0] rem_in   [NS];
  logic [TW-1:0] root_in  [NS];
  logic [RW-1:0] rad_nxt  [NS];
  logic [MW-1:0] rem_nxt  [NS];
  logic [TW-1:0] root_nxt [NS];
  logic [RW-1:0] rad_r    [NS];
  logic [MW-1:0] rem_r    [NS];
  logic [TW-1:0] root_r   [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rad_in[s]  = rad;
      assign rem_in[s]  = '0;
      assign root_in[s] = '0;
    end else begin : g_next
      assign rad_in[s]  = rad_r[s-1];
      assign rem_in[s]  = rem_r[s-1];
      assign root_in[s] = root_r[s-1];
    end

    always_comb begin
      logic [MW+1:0] cur;
      logic [MW+1:0] trial;
      rad_nxt[s]  = rad_in[s];
      rem_nxt[s]  = rem_in[s];
      root_nxt[s] = root_in[s];
      for (int t = 0; t < 2; t++) begin
        if (s * 2 + t < STEPS) begin
          cur        = {rem_nxt[s], rad_nxt[s][RW-1:RW-2]};
          rad_nxt[s] = {rad_nxt[s][RW-3:0], 2'b00};
          trial      = (MW+2)'({root_nxt[s], 2'b01});
          if (cur >= trial) begin
            cur         = cur - trial;
            root_nxt[s] = {root_nxt[s][TW-2:0], 1'b1};
          end else begin
            root_nxt[s] = {root_nxt[s][TW-2:0], 1'b0};
          end
          rem_nxt[s] = cur[MW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s]  <= rad_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
      end
    end
  end

  assign root = root_r[NS-1][dcp_pkg::LEN_W-1:0];

endmodule
`default_nettype wire
